>>> rtl/core/proximity_zone_monitor_top_macros.svh
// ----------------------------------------------------------------------------
// Proximity zone monitor assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_ZONE_MONITOR_TOP_MACROS_SVH
`define PROXIMITY_ZONE_MONITOR_TOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define PZM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define PZM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pzm_pkg.sv
// ----------------------------------------------------------------------------
// Proximity zone monitor package
// Widths, codes, reset values and divider constants shared by the monitor.
// ----------------------------------------------------------------------------
package pzm_pkg;

	// Echo counter width of the timer front end; input fields stay 16 bits
	localparam int ECHO_COUNT_BITS = 16;
	localparam int TICKS_W = 16;
	localparam logic [TICKS_W-1:0] ECHO_MASK =
		TICKS_W'((64'd1 << ECHO_COUNT_BITS) - 64'd1);

	localparam int CM_W  = 11;
	localparam int CFG_W = 9;
	localparam int IDX_W = 3;

	// Divide by 58 as multiply by ceil(2^22/58) and shift; exact for 16-bit counts
	localparam int DIV58_SHIFT = 22;
	localparam int DIV58_MW = 17;
	localparam logic [DIV58_MW-1:0] DIV58_MULT = 17'd72316;
	localparam int DIV58_PW = TICKS_W + DIV58_MW;

	// Filter sum newest + 4*previous + oldest, at most 6*2047
	localparam int SUM_W = 14;
	// Divide by 6 as multiply by ceil(2^16/6) and shift; exact below 2^15
	localparam int DIV6_SHIFT = 16;
	localparam logic [SUM_W-1:0] DIV6_MULT = 14'd10923;
	localparam int DIV6_PW = 2 * SUM_W;

	localparam logic [CM_W-1:0] RANGE_LIMIT_CM = 11'd400;

	localparam logic [CFG_W-1:0] RST_REAR_GREEN   = 9'd300;
	localparam logic [CFG_W-1:0] RST_REAR_YELLOW  = 9'd200;
	localparam logic [CFG_W-1:0] RST_REAR_ORANGE  = 9'd100;
	localparam logic [CFG_W-1:0] RST_FRONT_TWO    = 9'd200;
	localparam logic [CFG_W-1:0] RST_FRONT_FOUR   = 9'd100;

	typedef enum logic [IDX_W-1:0] {
		REG_REAR_GREEN  = 3'd0,
		REG_REAR_YELLOW = 3'd1,
		REG_REAR_ORANGE = 3'd2,
		REG_FRONT_TWO   = 3'd3,
		REG_FRONT_FOUR  = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ZONE_NONE   = 3'd0,
		ZONE_GREEN  = 3'd1,
		ZONE_YELLOW = 3'd2,
		ZONE_ORANGE = 3'd3,
		ZONE_RED    = 3'd4
	} zone_t;

	typedef enum logic [1:0] {
		BEEP_NONE   = 2'd0,
		BEEP_DOUBLE = 2'd1,
		BEEP_QUAD   = 2'd2
	} beep_t;

	typedef enum logic [1:0] {
		LVL_NONE = 2'd0,
		LVL_LOW  = 2'd1,
		LVL_HIGH = 2'd2
	} level_t;

endpackage

>>> rtl/core/proximity_zone_monitor_top.sv
// ----------------------------------------------------------------------------
// Proximity zone monitor
// Rear/front ultrasonic echo to distance, smoothing, rear zone and beep request.
// ----------------------------------------------------------------------------
// The monitor takes one item per clock while the output is not stalled, and
// returns one result per item. Each item holds a rear and a front echo width
// in timer ticks. Stage 1 registers the input, stage 2 converts ticks to
// centimeters (truncating divide by 58 through a reciprocal multiplier), stage
// 3 forms the (1,4,1) filter sum and shifts the per-channel history, stage 4
// divides that sum by 6 (reciprocal multiplier), and the result register adds
// the rear zone and the front beep request. The two multipliers set the stage
// split; throughput is one item per cycle while out_ready is high, and each
// stage holds its item while the stage after it cannot take a new one. The
// history is zero after reset, so the first two results of each channel are
// warm-up values. A double beep is requested on entering the low warning
// level from no warning, a quad beep on entering the high level; distances
// equal to a threshold leave the warning level unchanged. Threshold registers
// are written through the configuration port; the user must write them only
// while no item is in flight, as the block itself does not enforce it.
module proximity_zone_monitor_top (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_write_en,
	input  logic [pzm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pzm_pkg::CFG_W-1:0]   cfg_data,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pzm_pkg::TICKS_W-1:0] rear_echo_ticks,
	input  logic [pzm_pkg::TICKS_W-1:0] front_echo_ticks,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pzm_pkg::CM_W-1:0]    rear_distance_cm,
	output logic [pzm_pkg::CM_W-1:0]    front_distance_cm,
	output logic [2:0]                  rear_zone,
	output logic [1:0]                  beep_request
);

`include "proximity_zone_monitor_top_macros.svh"

	// Threshold registers
	logic [pzm_pkg::CFG_W-1:0] rear_green_q;
	logic [pzm_pkg::CFG_W-1:0] rear_yellow_q;
	logic [pzm_pkg::CFG_W-1:0] rear_orange_q;
	logic [pzm_pkg::CFG_W-1:0] front_two_q;
	logic [pzm_pkg::CFG_W-1:0] front_four_q;

	// Pipeline valid bits and per-stage ready
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// Stage payloads
	logic [pzm_pkg::TICKS_W-1:0] rear_ticks_s1, front_ticks_s1;
	logic [pzm_pkg::CM_W-1:0]    rear_cm_s2, front_cm_s2;
	logic [pzm_pkg::SUM_W-1:0]   rear_sum_s3, front_sum_s3;
	logic [pzm_pkg::CM_W-1:0]    rear_dist_s4, front_dist_s4;
	logic [pzm_pkg::CM_W-1:0]    rear_dist_s5, front_dist_s5;
	pzm_pkg::zone_t              rear_zone_s5;
	pzm_pkg::beep_t              beep_s5;

	// Channel history: h0 previous sample, h1 oldest sample
	logic [pzm_pkg::CM_W-1:0] rear_h0_q, rear_h1_q, front_h0_q, front_h1_q;

	pzm_pkg::level_t level_q, level_d;
	pzm_pkg::zone_t  zone_d;
	pzm_pkg::beep_t  beep_d;

	logic [pzm_pkg::DIV58_PW-1:0] rear_prod58, front_prod58;
	logic [pzm_pkg::SUM_W-1:0]    rear_sum_d, front_sum_d;
	logic [pzm_pkg::DIV6_PW-1:0]  rear_prod6, front_prod6;

	// ------------------------------------------------------------------
	// Configuration writes; drop unknown indexes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rear_green_q  <= pzm_pkg::RST_REAR_GREEN;
			rear_yellow_q <= pzm_pkg::RST_REAR_YELLOW;
			rear_orange_q <= pzm_pkg::RST_REAR_ORANGE;
			front_two_q   <= pzm_pkg::RST_FRONT_TWO;
			front_four_q  <= pzm_pkg::RST_FRONT_FOUR;
		end else if (cfg_write_en) begin
			unique case (pzm_pkg::cfg_reg_t'(cfg_index))
				pzm_pkg::REG_REAR_GREEN:  rear_green_q  <= cfg_data;
				pzm_pkg::REG_REAR_YELLOW: rear_yellow_q <= cfg_data;
				pzm_pkg::REG_REAR_ORANGE: rear_orange_q <= cfg_data;
				pzm_pkg::REG_FRONT_TWO:   front_two_q   <= cfg_data;
				pzm_pkg::REG_FRONT_FOUR:  front_four_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: a stage takes a new item when empty or draining
	// ------------------------------------------------------------------
	assign rdy_s5   = !valid_s5 || out_ready;
	assign rdy_s4   = !valid_s4 || rdy_s5;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture echo widths, cut to the counter width
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			rear_ticks_s1  <= rear_echo_ticks & pzm_pkg::ECHO_MASK;
			front_ticks_s1 <= front_echo_ticks & pzm_pkg::ECHO_MASK;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: ticks to centimeters; 16-bit counts stay below 1130 cm
	// ------------------------------------------------------------------
	assign rear_prod58  = pzm_pkg::DIV58_PW'(rear_ticks_s1) *
		pzm_pkg::DIV58_PW'(pzm_pkg::DIV58_MULT);
	assign front_prod58 = pzm_pkg::DIV58_PW'(front_ticks_s1) *
		pzm_pkg::DIV58_PW'(pzm_pkg::DIV58_MULT);

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			rear_cm_s2  <= rear_prod58[pzm_pkg::DIV58_SHIFT +: pzm_pkg::CM_W];
			front_cm_s2 <= front_prod58[pzm_pkg::DIV58_SHIFT +: pzm_pkg::CM_W];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: filter sum and history shift
	// ------------------------------------------------------------------
	assign rear_sum_d  = pzm_pkg::SUM_W'(rear_cm_s2) +
		(pzm_pkg::SUM_W'(rear_h0_q) << 2) + pzm_pkg::SUM_W'(rear_h1_q);
	assign front_sum_d = pzm_pkg::SUM_W'(front_cm_s2) +
		(pzm_pkg::SUM_W'(front_h0_q) << 2) + pzm_pkg::SUM_W'(front_h1_q);

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			rear_sum_s3  <= rear_sum_d;
			front_sum_s3 <= front_sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rear_h0_q  <= '0;
			rear_h1_q  <= '0;
			front_h0_q <= '0;
			front_h1_q <= '0;
		end else if (rdy_s3 && valid_s2) begin
			rear_h1_q  <= rear_h0_q;
			rear_h0_q  <= rear_cm_s2;
			front_h1_q <= front_h0_q;
			front_h0_q <= front_cm_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: divide the filter sum by 6
	// ------------------------------------------------------------------
	assign rear_prod6  = pzm_pkg::DIV6_PW'(rear_sum_s3) *
		pzm_pkg::DIV6_PW'(pzm_pkg::DIV6_MULT);
	assign front_prod6 = pzm_pkg::DIV6_PW'(front_sum_s3) *
		pzm_pkg::DIV6_PW'(pzm_pkg::DIV6_MULT);

	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			rear_dist_s4  <= rear_prod6[pzm_pkg::DIV6_SHIFT +: pzm_pkg::CM_W];
			front_dist_s4 <= front_prod6[pzm_pkg::DIV6_SHIFT +: pzm_pkg::CM_W];
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: rear zone, front warning level and beep request
	// ------------------------------------------------------------------
	always_comb begin
		priority if (rear_dist_s4 >= pzm_pkg::RANGE_LIMIT_CM)
			zone_d = pzm_pkg::ZONE_NONE;
		else if (rear_dist_s4 >= pzm_pkg::CM_W'(rear_green_q))
			zone_d = pzm_pkg::ZONE_GREEN;
		else if (rear_dist_s4 >= pzm_pkg::CM_W'(rear_yellow_q))
			zone_d = pzm_pkg::ZONE_YELLOW;
		else if (rear_dist_s4 >= pzm_pkg::CM_W'(rear_orange_q))
			zone_d = pzm_pkg::ZONE_ORANGE;
		else
			zone_d = pzm_pkg::ZONE_RED;
	end

	always_comb begin
		level_d = level_q;
		beep_d  = pzm_pkg::BEEP_NONE;
		priority if (front_dist_s4 < pzm_pkg::RANGE_LIMIT_CM &&
				front_dist_s4 > pzm_pkg::CM_W'(front_two_q)) begin
			level_d = pzm_pkg::LVL_NONE;
		end else if (front_dist_s4 < pzm_pkg::CM_W'(front_two_q) &&
				front_dist_s4 > pzm_pkg::CM_W'(front_four_q)) begin
			// Double beep only when coming from no warning
			if (level_q == pzm_pkg::LVL_NONE)
				beep_d = pzm_pkg::BEEP_DOUBLE;
			level_d = pzm_pkg::LVL_LOW;
		end else if (front_dist_s4 < pzm_pkg::CM_W'(front_four_q) &&
				level_q != pzm_pkg::LVL_HIGH) begin
			beep_d  = pzm_pkg::BEEP_QUAD;
			level_d = pzm_pkg::LVL_HIGH;
		end else begin
			// Hold level on a threshold tie, out of range, or already high
			level_d = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= pzm_pkg::LVL_NONE;
		end else if (rdy_s5 && valid_s4) begin
			level_q <= level_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && valid_s4) begin
			rear_dist_s5  <= rear_dist_s4;
			front_dist_s5 <= front_dist_s4;
			rear_zone_s5  <= zone_d;
			beep_s5       <= beep_d;
		end
	end

	assign out_valid         = valid_s5;
	assign rear_distance_cm  = rear_dist_s5;
	assign front_distance_cm = front_dist_s5;
	assign rear_zone         = rear_zone_s5;
	assign beep_request      = beep_s5;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`PZM_ASSERT_NOW(a_double_from_none, rdy_s5 && valid_s4 && beep_d == pzm_pkg::BEEP_DOUBLE, level_q == pzm_pkg::LVL_NONE, "double beep requested outside no-warning level")
	`PZM_ASSERT_NEXT(a_quad_enters_high, rdy_s5 && valid_s4 && beep_d == pzm_pkg::BEEP_QUAD, level_q == pzm_pkg::LVL_HIGH, "quad beep did not enter high level")
	`PZM_ASSERT_NOW(a_zone_none_range, valid_s5, (rear_zone_s5 == pzm_pkg::ZONE_NONE) == (rear_dist_s5 >= pzm_pkg::RANGE_LIMIT_CM), "rear zone none disagrees with range limit")
	`PZM_ASSERT_NEXT(a_history_shift, rdy_s3 && valid_s2, rear_h1_q == $past(rear_h0_q) && front_h1_q == $past(front_h0_q), "history did not shift")

endmodule

>>> tb/tb_proximity_zone_monitor_top.sv
// ----------------------------------------------------------------------------
// Proximity zone monitor testbench
// Drives rear/front echo items through the valid/ready input under random gaps
// and stalls, predicts every filtered distance, rear zone and beep request, and
// compares each result field by field across several threshold settings.
// ----------------------------------------------------------------------------
module tb_proximity_zone_monitor_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pzm_pkg::*;

	localparam int TICKS_PER_CM    = 58;
	localparam int DIST_MAX_CM     = 2047;
	localparam int IDLE_PCT        = 30;
	localparam int ITEMS_PER_PHASE = 104;
	localparam int HOLD_AT         = 400;
	localparam int HOLD_CYCLES     = 200;
	localparam int DRAIN_CYCLES    = 20;
	localparam logic [IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;

	// One input item and one predicted result
	typedef struct packed {
		logic [TICKS_W-1:0] rear;
		logic [TICKS_W-1:0] front;
	} echo_t;

	typedef struct packed {
		logic [CM_W-1:0] rear_cm;
		logic [CM_W-1:0] front_cm;
		zone_t           zone;
		beep_t           beep;
	} readout_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write_en = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [TICKS_W-1:0] rear_echo_ticks = '0;
	logic [TICKS_W-1:0] front_echo_ticks = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CM_W-1:0]    rear_distance_cm;
	logic [CM_W-1:0]    front_distance_cm;
	logic [2:0]         rear_zone;
	logic [1:0]         beep_request;

	proximity_zone_monitor_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.rear_echo_ticks   (rear_echo_ticks),
		.front_echo_ticks  (front_echo_ticks),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.rear_distance_cm  (rear_distance_cm),
		.front_distance_cm (front_distance_cm),
		.rear_zone         (rear_zone),
		.beep_request      (beep_request)
	);

	always #5 clk = ~clk;

	// Items waiting to be offered, and readouts waiting to come out
	echo_t    echoes_to_send[$];
	readout_t readouts_due[$];

	// Predictor state: thresholds as last written, filter history, warning level
	logic [CFG_W-1:0] green_cm  = RST_REAR_GREEN;
	logic [CFG_W-1:0] yellow_cm = RST_REAR_YELLOW;
	logic [CFG_W-1:0] orange_cm = RST_REAR_ORANGE;
	logic [CFG_W-1:0] two_cm    = RST_FRONT_TWO;
	logic [CFG_W-1:0] four_cm   = RST_FRONT_FOUR;
	logic [CM_W-1:0]  rear_hist[2]  = '{default: '0};
	logic [CM_W-1:0]  front_hist[2] = '{default: '0};
	level_t           warn_level = LVL_NONE;

	// Both sides run without gaps while this is set
	logic gapless = 1'b0;

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int settings_used = 1;
	int zone_seen[5] = '{default: 0};
	int beep_seen[3] = '{default: 0};
	int rear_walk = 200;
	int front_walk = 200;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Cut to the counter width, divide by 58 truncating, saturate to 11 bits
	function automatic logic [CM_W-1:0] echo_to_cm(input logic [TICKS_W-1:0] ticks);
		int unsigned cm;
		cm = int'(ticks & ECHO_MASK) / TICKS_PER_CM;
		if (cm > DIST_MAX_CM)
			cm = DIST_MAX_CM;
		return CM_W'(cm);
	endfunction

	// Truncating (1,4,1)/6 over newest, previous and oldest sample
	function automatic logic [CM_W-1:0] smooth3(input logic [CM_W-1:0] newest,
			input logic [CM_W-1:0] prev, input logic [CM_W-1:0] oldest);
		int unsigned sum;
		sum = int'(newest) + 4 * int'(prev) + int'(oldest);
		return CM_W'((sum / 6) & DIST_MAX_CM);
	endfunction

	// Advance the predictor by one accepted item and return its readout
	function automatic readout_t compute_readout(input logic [TICKS_W-1:0] rear_ticks,
			input logic [TICKS_W-1:0] front_ticks);
		readout_t r;
		logic [CM_W-1:0] rear_new;
		logic [CM_W-1:0] front_new;
		rear_new  = echo_to_cm(rear_ticks);
		front_new = echo_to_cm(front_ticks);
		r.rear_cm  = smooth3(rear_new, rear_hist[0], rear_hist[1]);
		r.front_cm = smooth3(front_new, front_hist[0], front_hist[1]);
		rear_hist[1]  = rear_hist[0];
		rear_hist[0]  = rear_new;
		front_hist[1] = front_hist[0];
		front_hist[0] = front_new;

		// Rear zone: out of range first, then thresholds from the top down
		if (r.rear_cm >= RANGE_LIMIT_CM)
			r.zone = ZONE_NONE;
		else if (r.rear_cm >= green_cm)
			r.zone = ZONE_GREEN;
		else if (r.rear_cm >= yellow_cm)
			r.zone = ZONE_YELLOW;
		else if (r.rear_cm >= orange_cm)
			r.zone = ZONE_ORANGE;
		else
			r.zone = ZONE_RED;

		// Front warning with hysteresis; a distance equal to a threshold holds
		r.beep = BEEP_NONE;
		if (r.front_cm < RANGE_LIMIT_CM && r.front_cm > two_cm) begin
			warn_level = LVL_NONE;
		end else if (r.front_cm < two_cm && r.front_cm > four_cm) begin
			if (warn_level == LVL_NONE)
				r.beep = BEEP_DOUBLE;
			warn_level = LVL_LOW;
		end else if (r.front_cm < four_cm && warn_level != LVL_HIGH) begin
			r.beep = BEEP_QUAD;
			warn_level = LVL_HIGH;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offer queued items, hold each one until it is taken
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_echo
		echo_t next_echo;
		logic  offer;
		if (!arst_n) begin
			in_valid         <= 1'b0;
			rear_echo_ticks  <= '0;
			front_echo_ticks <= '0;
		end else begin
			// Predict at the edge that accepts the item
			if (in_valid && in_ready) begin
				readouts_due.push_back(compute_readout(rear_echo_ticks, front_echo_ticks));
				items_sent++;
			end
			// Pick the next item only once the current one is gone
			if (!in_valid || in_ready) begin
				offer = echoes_to_send.size() != 0 &&
					(gapless || $urandom_range(0, 99) >= IDLE_PCT);
				if (offer) begin
					next_echo = echoes_to_send.pop_front();
					in_valid         <= 1'b1;
					rear_echo_ticks  <= next_echo.rear;
					front_echo_ticks <= next_echo.front;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: take results, compare against the oldest prediction
	// ------------------------------------------------------------------------
	function automatic void check_field(input string field, input int expected,
			input int actual);
		if (expected != actual) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, field, expected, actual);
			mismatches++;
		end
	endfunction

	int   hold_left = 0;
	logic held_off = 1'b0;

	always @(posedge clk or negedge arst_n) begin : check_readout
		readout_t due;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			held_off  <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (readouts_due.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual %0d %0d %0d %0d",
						$time, rear_distance_cm, front_distance_cm, rear_zone, beep_request);
					mismatches++;
				end else begin
					due = readouts_due.pop_front();
					check_field("rear_distance_cm", due.rear_cm, rear_distance_cm);
					check_field("front_distance_cm", due.front_cm, front_distance_cm);
					check_field("rear_zone", due.zone, rear_zone);
					check_field("beep_request", due.beep, beep_request);
					zone_seen[due.zone]++;
					beep_seen[due.beep]++;
				end
				results_seen++;
			end
			// Once, drop ready for a long stretch so the pipeline backs up
			// into the input while the driver keeps offering
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!held_off && results_seen >= HOLD_AT) begin
				out_ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				held_off  <= 1'b1;
			end else begin
				out_ready <= gapless || $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Write one register at a rising edge and mirror it in the predictor
	task automatic write_threshold(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		case (idx)
			REG_REAR_GREEN:  green_cm  = value;
			REG_REAR_YELLOW: yellow_cm = value;
			REG_REAR_ORANGE: orange_cm = value;
			REG_FRONT_TWO:   two_cm    = value;
			REG_FRONT_FOUR:  four_cm   = value;
			default: ;  // unused index, the block ignores it
		endcase
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic apply_thresholds(input int green, input int yellow, input int orange,
			input int two, input int four);
		write_threshold(REG_REAR_GREEN, CFG_W'(green));
		write_threshold(REG_REAR_YELLOW, CFG_W'(yellow));
		write_threshold(REG_REAR_ORANGE, CFG_W'(orange));
		write_threshold(REG_FRONT_TWO, CFG_W'(two));
		write_threshold(REG_FRONT_FOUR, CFG_W'(four));
		settings_used++;
	endtask

	// Queue items between clock edges so the driver never races the push
	task automatic push_echo(input int rear, input int front);
		echo_t e;
		e.rear  = TICKS_W'(rear);
		e.front = TICKS_W'(front);
		@(negedge clk);
		echoes_to_send.push_back(e);
	endtask

	// Hold both channels at a distance; three equal samples filter to it exactly
	task automatic push_steady(input int rear_cm, input int front_cm, input int count);
		repeat (count)
			push_echo(rear_cm * TICKS_PER_CM + $urandom_range(0, TICKS_PER_CM - 1),
				front_cm * TICKS_PER_CM + $urandom_range(0, TICKS_PER_CM - 1));
	endtask

	function automatic int walk_step(input int cm);
		cm = cm + int'($urandom_range(0, 40)) - 20;
		if (cm < 0)
			cm = 0;
		if (cm > 460)
			cm = 460;
		return cm;
	endfunction

	// Mostly slow drifts across the thresholds so the warning level walks
	// through its states; the rest is raw counts and all-zero/all-one words
	task automatic push_random_items(input int count);
		int pick;
		int rear;
		int front;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			rear_walk  = walk_step(rear_walk);
			front_walk = walk_step(front_walk);
			if (pick < 60) begin
				rear  = rear_walk * TICKS_PER_CM + $urandom_range(0, TICKS_PER_CM - 1);
				front = front_walk * TICKS_PER_CM + $urandom_range(0, TICKS_PER_CM - 1);
			end else if (pick < 85) begin
				rear  = $urandom_range(0, 65535);
				front = $urandom_range(0, 65535);
			end else begin
				rear  = $urandom_range(0, 1) ? 65535 : 0;
				front = $urandom_range(0, 1) ? 65535 : 0;
			end
			push_echo(rear, front);
		end
	endtask

	// Wait until every queued item went in and every readout came out,
	// then let the pipeline settle before touching the registers
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (echoes_to_send.size() != 0 || in_valid || readouts_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Writes to unused indexes must leave every threshold alone
		for (int i = REG_FIRST_UNUSED; i <= 2**IDX_W - 1; i++)
			write_threshold(IDX_W'(i), CFG_W'($urandom_range(0, 2**CFG_W - 1)));

		// Directed pass under reset thresholds: warm-up from a cleared
		// history, full-scale counts, every zone, every beep, front distance
		// equal to each threshold, already at high warning, back to low
		push_echo(0, 0);
		push_echo(65535, 65535);
		push_echo(65535, 65535);
		push_echo(65535, 65535);
		push_steady(300, 250, 3);
		push_steady(200, 200, 3);
		push_steady(100, 150, 3);
		push_steady(50, 100, 3);
		push_steady(399, 50, 3);
		push_steady(400, 150, 2);
		push_random_items(ITEMS_PER_PHASE);
		wait_quiet();

		// Lowest legal thresholds, with both sides running flat out
		gapless <= 1'b1;
		apply_thresholds(3, 2, 1, 2, 1);
		push_random_items(ITEMS_PER_PHASE);
		wait_quiet();
		gapless <= 1'b0;

		// Highest legal thresholds
		apply_thresholds(400, 399, 398, 400, 399);
		push_random_items(ITEMS_PER_PHASE);
		wait_quiet();

		// Thresholds out of order: some zones and levels unreachable
		apply_thresholds(100, 200, 300, 100, 200);
		push_random_items(ITEMS_PER_PHASE);
		wait_quiet();

		// Rear green above the range limit, register words at all ones/zeros
		apply_thresholds(2**CFG_W - 1, 450, 0, 2**CFG_W - 1, 0);
		push_random_items(ITEMS_PER_PHASE);
		wait_quiet();

		// Random ordered thresholds inside the documented ranges
		begin : ordered_random
			int orange;
			int yellow;
			int four;
			orange = $urandom_range(1, 396);
			yellow = $urandom_range(orange + 1, 398);
			four   = $urandom_range(1, 398);
			apply_thresholds($urandom_range(yellow + 1, 400), yellow, orange,
				$urandom_range(four + 1, 400), four);
		end
		push_random_items(ITEMS_PER_PHASE);
		wait_quiet();

		// Any 9-bit word in each register
		apply_thresholds($urandom_range(0, 2**CFG_W - 1), $urandom_range(0, 2**CFG_W - 1),
			$urandom_range(0, 2**CFG_W - 1), $urandom_range(0, 2**CFG_W - 1),
			$urandom_range(0, 2**CFG_W - 1));
		push_random_items(ITEMS_PER_PHASE);
		wait_quiet();

		// Back to the reset values through the port
		apply_thresholds(RST_REAR_GREEN, RST_REAR_YELLOW, RST_REAR_ORANGE,
			RST_FRONT_TWO, RST_FRONT_FOUR);
		push_random_items(ITEMS_PER_PHASE);
		wait_quiet();

		repeat (DRAIN_CYCLES) @(negedge clk);

		// Anything still outstanding never came out
		if (readouts_due.size() != 0) begin
			$display("%0t ns: %0d readouts never arrived, expected none left, actual %0d",
				$time, readouts_due.size(), readouts_due.size());
			mismatches++;
		end

		$display("Run covered %0d echo items, %0d results, %0d threshold settings, %0d mismatches",
			items_sent, results_seen, settings_used, mismatches);
		$display("Zones none/green/yellow/orange/red %0d/%0d/%0d/%0d/%0d, beeps double %0d quad %0d",
			zone_seen[ZONE_NONE], zone_seen[ZONE_GREEN], zone_seen[ZONE_YELLOW],
			zone_seen[ZONE_ORANGE], zone_seen[ZONE_RED],
			beep_seen[BEEP_DOUBLE], beep_seen[BEEP_QUAD]);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2_000_000;
		$display("Timeout with %0d readouts outstanding", readouts_due.size());
		$display("FAIL");
		$finish;
	end

endmodule
